@@ rtl/lpim_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lpim_pkg
// Types and codes shared by the linear probe index map and its channels.
// ============================================================================
package lpim_pkg;

    localparam int KEY_W  = 32;   // key width
    localparam int SLOT_W = 12;   // entity slot width on the result channel
    localparam int MAX_W  = 13;   // max_entities register width

    localparam logic [MAX_W-1:0] MAX_RESET = 13'd4096;

    typedef logic [1:0]        req_type_t;
    typedef logic [2:0]        status_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SLOT_W-1:0] slot_t;

    // request types; the unused code behaves as a plain lookup
    localparam req_type_t REQ_LOOKUP = 2'd0;
    localparam req_type_t REQ_ADD    = 2'd1;
    localparam req_type_t REQ_CLEAR  = 2'd2;

    // result status codes
    localparam status_t ST_FOUND       = 3'd0;
    localparam status_t ST_ADDED       = 3'd1;
    localparam status_t ST_ABSENT      = 3'd2;
    localparam status_t ST_REGION_FULL = 3'd3;
    localparam status_t ST_TABLE_FULL  = 3'd4;
    localparam status_t ST_INVALID     = 3'd5;
    localparam status_t ST_CLEARED     = 3'd6;

    // one table entry: key (zero means empty) and its bound entity slot
    typedef struct packed {
        key_t  key;
        slot_t slot;
    } entry_t;

endpackage

@@ rtl/lpim_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lpim channels
// Valid/ready channels for requests into the map and results out of it.
// ============================================================================

// request channel: request type and key
interface lpim_req_if;
    logic                valid;
    logic                ready;
    lpim_pkg::req_type_t req_type;
    lpim_pkg::key_t      key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

// result channel: status and entity slot
interface lpim_res_if;
    logic              valid;
    logic              ready;
    lpim_pkg::status_t status;
    lpim_pkg::slot_t   entity_slot;

    modport source (output valid, output status, output entity_slot, input ready);
    modport sink   (input valid, input status, input entity_slot, output ready);
endinterface

@@ rtl/linear_probe_index_map.sv @@
`timescale 1ns / 1ps
// ============================================================================
// linear_probe_index_map
// Open-addressing hash map from nonzero keys to dense entity slots, linear
// probing over one table memory, one entry read per cycle.
// ============================================================================
//
//  channel   dir  handshake     payload
//  -------   ---  ---------     -------
//  req       in   valid/ready   req_type, key
//  res       out  valid/ready   status, entity_slot
//  cfg       in   cfg_we        cfg_wdata (max_entities)
//
// One request is in flight at a time. A request that hits or ends at its home
// entry goes through accept, probe and result (S_IDLE, S_PROBE, S_DONE);
// each further probe adds an S_PROBE step, set by the single table read port.
// A table size that is not a power of two adds a home computation step,
// S_HASH (reciprocal multiply at accept, then the remainder). Invalid key:
// accept, then result. Clear sweeps the table one entry a cycle, then gives
// its result. After reset the same sweep runs with req.ready low.
// A waiting result in the output register does not block the next request.
// ============================================================================
module linear_probe_index_map #(
    parameter int TABLE_SLOTS     = 4096,
    parameter int ENTITY_CAPACITY = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lpim_req_if.sink                  req,
    lpim_res_if.source                res,
    input  logic                      cfg_we,
    input  logic [lpim_pkg::MAX_W-1:0] cfg_wdata
);
    import lpim_pkg::*;

    localparam int  IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam bit  IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam int  CNT_LIM = (ENTITY_CAPACITY < 8191) ? ENTITY_CAPACITY : 8191;
    localparam int  CNT_W   = $clog2(CNT_LIM + 1);
    localparam int  CAP_W   = $clog2(ENTITY_CAPACITY + 1);
    localparam int  CMP_W   = (CAP_W > MAX_W) ? CAP_W : MAX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    // rounded-up reciprocal of the table size, exact for every 32-bit key
    localparam logic [63:0]      RECIP_ONE = 64'd1 << (32 + IDX_W);
    localparam logic [32:0]      RECIP_M   =
        33'((RECIP_ONE + 64'(TABLE_SLOTS - 1)) / 64'(TABLE_SLOTS));
    localparam logic [IDX_W-1:0] SLOTS_LOW = IDX_W'(TABLE_SLOTS);

    // state codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // table memory
    entry_t table_mem [TABLE_SLOTS];
    entry_t rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // control and request registers
    logic [2:0]       state_reg,    state_next;
    logic             add_reg,      add_next;
    key_t             key_reg,      key_next;
    logic [IDX_W-1:0] addr_reg,     addr_next;
    logic [IDX_W-1:0] pcnt_reg,     pcnt_next;
    logic [64:0]      prod_reg,     prod_next;
    logic             clr_resp_reg, clr_resp_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic [MAX_W-1:0] max_reg;
    status_t          status_reg,   status_next;
    slot_t            slot_reg,     slot_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    slot_t            out_slot_reg,   out_slot_next;

    logic             out_free;
    logic [IDX_W-1:0] addr_wrap;
    logic [IDX_W-1:0] quot_low;
    logic [IDX_W-1:0] home_addr;
    logic             hit;
    logic             empty;
    logic             region_full;

    assign out_free  = !out_valid_reg || res.ready;
    assign addr_wrap = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
    assign hit       = (rd_reg.key == key_reg);
    assign empty     = (rd_reg.key == '0);

    // limit check against the register and the fixed capacity
    assign region_full = (CMP_W'(cnt_reg) >= CMP_W'(max_reg)) ||
                         (CMP_W'(cnt_reg) >= CMP_W'(ENTITY_CAPACITY));

    // key modulo TABLE_SLOTS: the remainder fits in IDX_W bits, so only the
    // low bits of the quotient and of quotient * TABLE_SLOTS are needed
    assign quot_low  = prod_reg[32+IDX_W +: IDX_W];
    assign home_addr = key_reg[IDX_W-1:0] - quot_low * SLOTS_LOW;

    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.entity_slot = out_slot_reg;

    // table memory: one write port, one registered read port; an add writes
    // in its probe cycle, so any later request reads the updated entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_reg <= table_mem[rd_addr];
    end

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        add_next        = add_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        pcnt_next       = pcnt_reg;
        prod_next       = prod_reg;
        clr_resp_next   = clr_resp_reg;
        cnt_next        = cnt_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        rd_addr         = addr_wrap;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = '0;

        case (state_reg)
            // sweep zeros through the table
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    if (clr_resp_reg)
                    begin
                        cnt_next    = '0;
                        status_next = ST_CLEARED;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            // take a request
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next = req.key;
                    add_next = (req.req_type == REQ_ADD);
                    if (req.req_type == REQ_CLEAR)
                    begin
                        clr_resp_next = 1'b1;
                        addr_next     = '0;
                        state_next    = S_CLEAR;
                    end
                    else if (req.key == '0)
                    begin
                        status_next = ST_INVALID;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                    else if (IS_POW2)
                    begin
                        rd_addr    = req.key[IDX_W-1:0];
                        addr_next  = req.key[IDX_W-1:0];
                        pcnt_next  = '0;
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        // 32 x 33 bit product with the reciprocal
                        prod_next  = 65'(req.key) * 65'(RECIP_M);
                        state_next = S_HASH;
                    end
                end
            end

            // home position for a table size not a power of two
            S_HASH:
            begin
                rd_addr    = home_addr;
                addr_next  = home_addr;
                pcnt_next  = '0;
                state_next = S_PROBE;
            end

            // check the entry read last cycle; the next one is already read
            S_PROBE:
            begin
                if (hit)
                begin
                    status_next = ST_FOUND;
                    slot_next   = rd_reg.slot;
                    state_next  = S_DONE;
                end
                else if (empty)
                begin
                    slot_next  = '0;
                    state_next = S_DONE;
                    if (!add_reg)
                    begin
                        status_next = ST_ABSENT;
                    end
                    else if (region_full)
                    begin
                        status_next = ST_REGION_FULL;
                    end
                    else
                    begin
                        wr_en        = 1'b1;
                        wr_data.key  = key_reg;
                        wr_data.slot = SLOT_W'(cnt_reg);
                        slot_next    = SLOT_W'(cnt_reg);
                        cnt_next     = cnt_reg + 1'b1;
                        status_next  = ST_ADDED;
                    end
                end
                else if (pcnt_reg == LAST_IDX)
                begin
                    status_next = ST_TABLE_FULL;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    addr_next = addr_wrap;
                    pcnt_next = pcnt_reg + 1'b1;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_slot_next   = slot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            clr_resp_reg  <= 1'b0;
            cnt_reg       <= '0;
            max_reg       <= MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            clr_resp_reg  <= clr_resp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        add_reg        <= add_next;
        key_reg        <= key_next;
        pcnt_reg       <= pcnt_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for linear_probe_index_map: requests go in, a
// prediction of the open-addressing map gives each expected status and slot,
// and every result is compared in order as it leaves the block.
// ============================================================================
module testbench;

    import lpim_pkg::*;

    localparam int TABLE_SLOTS     = 4096;
    localparam int ENTITY_CAPACITY = 4096;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int LONG_HOLD       = 400;
    localparam int MAX_GAP         = 8;
    localparam int MAX_PRINTED     = 30;

    // unused request code, served as a plain lookup
    localparam req_type_t REQ_SPARE = 2'd3;

    localparam logic [MAX_W-1:0] MAX_ALL_ONES = 13'h1FFF;

    typedef struct packed {
        status_t status;
        slot_t   slot;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Map prediction and result checking
    // ------------------------------------------------------------------------
    class map_scoreboard;
        key_t             stored_key  [TABLE_SLOTS];
        slot_t            stored_slot [TABLE_SLOTS];
        logic [MAX_W-1:0] bound_count;
        logic [MAX_W-1:0] slot_limit;
        outcome_t         pending_outcomes[$];
        int               mismatches;
        int               accepted;
        int               checked;
        int               status_seen[7];

        function new();
            empty_table();
            slot_limit = MAX_RESET;
            mismatches = 0;
            accepted   = 0;
            checked    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void empty_table();
            foreach (stored_key[i]) stored_key[i] = '0;
            bound_count = '0;
        endfunction

        // one request against the predicted table
        function outcome_t lookup_or_bind(req_type_t kind, key_t key);
            outcome_t o;
            int       idx;
            int       pos;
            o.status = ST_ABSENT;
            o.slot   = '0;
            if (kind == REQ_CLEAR) begin
                empty_table();
                o.status = ST_CLEARED;
            end
            else if (key == '0) begin
                o.status = ST_INVALID;
            end
            else begin
                // linear probe from the home entry, wrapping
                idx = int'(key % TABLE_SLOTS);
                pos = -1;
                for (int n = 0; n < TABLE_SLOTS && pos < 0; n++) begin
                    if (stored_key[idx] == '0 || stored_key[idx] == key)
                        pos = idx;
                    else
                        idx = (idx + 1) % TABLE_SLOTS;
                end
                if (pos < 0)
                    o.status = ST_TABLE_FULL;
                else if (stored_key[pos] == key) begin
                    o.status = ST_FOUND;
                    o.slot   = stored_slot[pos];
                end
                else if (kind != REQ_ADD)
                    o.status = ST_ABSENT;
                else if (bound_count >= slot_limit || bound_count >= ENTITY_CAPACITY)
                    o.status = ST_REGION_FULL;
                else begin
                    o.status         = ST_ADDED;
                    o.slot           = bound_count[SLOT_W-1:0];
                    stored_key[pos]  = key;
                    stored_slot[pos] = bound_count[SLOT_W-1:0];
                    bound_count      = bound_count + 1'b1;
                end
            end
            return o;
        endfunction

        function void note_request(req_type_t kind, key_t key);
            accepted++;
            pending_outcomes.push_back(lookup_or_bind(kind, key));
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("ERROR @%0t: %s", $time, what);
        endtask

        task check_result(status_t status, slot_t slot);
            outcome_t want;
            if (pending_outcomes.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d slot %0d",
                                          status, slot));
            else begin
                want = pending_outcomes.pop_front();
                checked++;
                if (want.status <= ST_CLEARED)
                    status_seen[want.status]++;
                if (status !== want.status)
                    report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                              checked, status, want.status));
                if (slot !== want.slot)
                    report_mismatch($sformatf("result %0d: slot %0d, expected %0d",
                                              checked, slot, want.slot));
            end
        endtask

        task check_leftovers();
            if (pending_outcomes.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          pending_outcomes.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [MAX_W-1:0] cfg_wdata;
    int               cycle_count;
    bit               long_hold_armed;
    bit               tx_burst;
    bit               rx_burst;

    map_scoreboard sb = new();

    lpim_req_if req_ch();
    lpim_res_if res_ch();

    linear_probe_index_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Idle draws; each side toggles now and then into a stretch without gaps
    // ------------------------------------------------------------------------
    function automatic int tx_gap();
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        return tx_burst ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic int rx_wait();
        if ($urandom_range(0, 39) == 0)
            rx_burst = !rx_burst;
        return rx_burst ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: valid stays high across back-to-back requests
    // ------------------------------------------------------------------------
    task automatic send_req(req_type_t kind, key_t key);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key      <= key;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        sb.note_request(kind, key);
    endtask

    // stop offering and let every outstanding request finish
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_entities(logic [MAX_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        sb.slot_limit  = value;
    endtask

    function automatic key_t key_at_home(logic [11:0] home);
        logic [19:0] upper;
        upper = 20'($urandom_range(1, 20'hFFFFF));
        return {upper, home};
    endfunction

    // ------------------------------------------------------------------------
    // Random traffic over a small pool of clustered keys
    // ------------------------------------------------------------------------
    task automatic run_random_phase(int n_items);
        key_t        pool[24];
        logic [11:0] homes[4];
        int          roll;
        int          pick;
        req_type_t   kind;
        homes[0] = 12'hFFE;
        for (int i = 1; i < 4; i++)
            homes[i] = 12'($urandom_range(0, TABLE_SLOTS - 1));
        foreach (pool[i])
            pool[i] = key_at_home(homes[i % 4] + 12'($urandom_range(0, 2)));
        send_req(REQ_CLEAR, $urandom());
        repeat (n_items)
        begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 23);
            if (roll < 45)
                send_req(REQ_ADD, pool[pick]);
            else if (roll < 70)
                send_req(REQ_LOOKUP, pool[pick]);
            else if (roll < 76)
                send_req(REQ_SPARE, pool[pick]);
            else if (roll < 86)
            begin
                kind = ($urandom_range(0, 1) == 0) ? REQ_LOOKUP : REQ_ADD;
                send_req(kind, $urandom());
            end
            else if (roll < 90)
            begin
                // zero key on every non-clear request type
                case ($urandom_range(0, 2))
                    0:       kind = REQ_LOOKUP;
                    1:       kind = REQ_ADD;
                    default: kind = REQ_SPARE;
                endcase
                send_req(kind, '0);
            end
            else if (roll < 92)
                send_req(REQ_CLEAR, $urandom());
            else
            begin
                // fresh key into a cluster
                pool[pick] = key_at_home(homes[pick % 4] + 12'($urandom_range(0, 3)));
                send_req(REQ_ADD, pool[pick]);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int rx_hold;
        rx_hold = 0;
        res_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                sb.check_result(res_ch.status, res_ch.entity_slot);
                rx_hold = rx_wait();
                if (long_hold_armed)
                begin
                    rx_hold         = LONG_HOLD;
                    long_hold_armed = 1'b0;
                end
                if (rx_hold > 0)
                    res_ch.ready <= 1'b0;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
                if (rx_hold == 0)
                    res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_LOOKUP;
        req_ch.key      <= '0;
        long_hold_armed  = 1'b0;
        tx_burst         = 1'b0;
        rx_burst         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // table sweep after reset holds ready low
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);

        // limit above capacity; zero keys, wrap-around, collisions, clear
        write_max_entities(MAX_ALL_ONES);
        send_req(REQ_LOOKUP, '0);
        send_req(REQ_ADD, '0);
        send_req(REQ_SPARE, '0);
        send_req(REQ_LOOKUP, 32'hFFFF_FFFF);
        send_req(REQ_ADD, 32'hFFFF_FFFF);
        send_req(REQ_ADD, 32'hFFFF_FFFF);
        send_req(REQ_SPARE, 32'hFFFF_FFFF);
        send_req(REQ_ADD, 32'h0000_0FFF);
        send_req(REQ_LOOKUP, 32'h0000_0FFF);
        send_req(REQ_ADD, 32'h0000_1000);
        send_req(REQ_LOOKUP, 32'h0000_1000);
        send_req(REQ_LOOKUP, 32'h0000_2000);
        send_req(REQ_ADD, 32'h8000_0000);
        send_req(REQ_CLEAR, 32'hFFFF_FFFF);
        send_req(REQ_LOOKUP, 32'hFFFF_FFFF);
        send_req(REQ_ADD, 32'h0000_0001);
        wait_all_results();

        // zero limit: no add may bind, present keys still found
        write_max_entities('0);
        send_req(REQ_ADD, 32'h0000_0002);
        send_req(REQ_LOOKUP, 32'h0000_0001);
        send_req(REQ_ADD, 32'h0000_0001);
        wait_all_results();

        write_max_entities(13'd2);
        send_req(REQ_ADD, 32'h0000_0003);
        send_req(REQ_ADD, 32'h0000_0004);
        send_req(REQ_CLEAR, 32'h0000_0000);
        wait_all_results();

        // random phases under several limits
        write_max_entities(13'($urandom_range(1, 8191)));
        run_random_phase(100);
        wait_all_results();

        write_max_entities(13'd7);
        long_hold_armed = 1'b1;
        run_random_phase(100);
        wait_all_results();

        write_max_entities(MAX_ALL_ONES);
        run_random_phase(100);
        wait_all_results();

        write_max_entities(13'($urandom_range(0, 40)));
        run_random_phase(100);
        wait_all_results();

        repeat (20) @(posedge clk);
        sb.check_leftovers();

        $display("Checked %0d results of %0d requests in %0d cycles, %0d mismatches",
                 sb.checked, sb.accepted, cycle_count, sb.mismatches);
        $display("found %0d, added %0d, absent %0d, region full %0d,",
                 sb.status_seen[ST_FOUND], sb.status_seen[ST_ADDED],
                 sb.status_seen[ST_ABSENT], sb.status_seen[ST_REGION_FULL]);
        $display("table full %0d, invalid %0d, cleared %0d",
                 sb.status_seen[ST_TABLE_FULL], sb.status_seen[ST_INVALID],
                 sb.status_seen[ST_CLEARED]);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ linear_probe_index_map.f @@
rtl/lpim_pkg.sv
rtl/lpim_if.sv
rtl/linear_probe_index_map.sv
tb/sv/testbench.sv
